@@ hdl/assert_macros.svh @@
// ---------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands for the RTL.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off while reset is asserted
`define AST_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, off while reset is asserted
`define AST_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) else $error(msg);

// Same-cycle implication that is also checked across reset
`define AST_ALWAYS(lbl, clk, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |-> (cons)) else $error(msg);

`endif

@@ hdl/sac_pkg.sv @@
// ---------------------------------------------------------------------------
// sac_pkg
// Types, character codes and class codes of the sequence alphabet classifier.
// ---------------------------------------------------------------------------
package sac_pkg;

  // Default counter width
  localparam int DEF_COUNT_BITS = 32;

  // Class codes
  localparam logic [2:0] CODE_DNA      = 3'd0;
  localparam logic [2:0] CODE_RNA      = 3'd1;
  localparam logic [2:0] CODE_NUMERIC  = 3'd2;
  localparam logic [2:0] CODE_AA_STOP  = 3'd3;
  localparam logic [2:0] CODE_AA       = 3'd4;
  localparam logic [2:0] CODE_UNKNOWN  = 3'd5;

  // Nucleotide guess codes
  localparam logic GUESS_DNA = 1'b0;
  localparam logic GUESS_RNA = 1'b1;

  // ASCII characters of interest
  localparam logic [7:0] CH_DASH  = 8'h2D;
  localparam logic [7:0] CH_QUEST = 8'h3F;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_X     = 8'h58;
  localparam logic [7:0] CH_A     = 8'h41;
  localparam logic [7:0] CH_C     = 8'h43;
  localparam logic [7:0] CH_G     = 8'h47;
  localparam logic [7:0] CH_N     = 8'h4E;
  localparam logic [7:0] CH_T     = 8'h54;
  localparam logic [7:0] CH_U     = 8'h55;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;

  // Fraction threshold 0.95 as a ratio of integers
  localparam int PCT_SCALE = 100;
  localparam int PCT_LIMIT = 95;
  // Extra product bits for a factor of up to PCT_SCALE
  localparam int PCT_BITS  = 7;

  typedef struct packed {
    logic [7:0] symbol;
    logic       last;
  } sac_in_t;

  typedef struct packed {
    logic [2:0] alphabet_code;
    logic       nucleotide_guess;
  } sac_out_t;

endpackage

@@ hdl/sac_counters.sv @@
// ---------------------------------------------------------------------------
// sac_counters
// Character decode and saturating counters; snapshots the counts on the
// last item and clears them.
// ---------------------------------------------------------------------------
module sac_counters #(
  parameter int COUNT_BITS = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  adv,
  input  logic                  item_valid,
  input  sac_pkg::sac_in_t      item,
  output logic                  snap_valid,
  output logic [COUNT_BITS-1:0] snap_total,
  output logic [COUNT_BITS-1:0] snap_gap,
  output logic [COUNT_BITS-1:0] snap_x,
  output logic [COUNT_BITS-1:0] snap_dna,
  output logic [COUNT_BITS-1:0] snap_rna,
  output logic [COUNT_BITS-1:0] snap_digit,
  output logic [COUNT_BITS-1:0] snap_stop
);
  import sac_pkg::*;

  function automatic logic [COUNT_BITS-1:0] sat_inc(
    input logic [COUNT_BITS-1:0] c,
    input logic                  en
  );
    sat_inc = (en && (c != '1)) ? c + COUNT_BITS'(1) : c;
  endfunction

  logic [COUNT_BITS-1:0] total_r, gap_r, x_r, dna_r, rna_r, digit_r, stop_r;
  logic [COUNT_BITS-1:0] total_nxt, gap_nxt, x_nxt, dna_nxt, rna_nxt, digit_nxt, stop_nxt;
  logic [COUNT_BITS-1:0] snap_total_r, snap_gap_r, snap_x_r, snap_dna_r;
  logic [COUNT_BITS-1:0] snap_rna_r, snap_digit_r, snap_stop_r;
  logic                  snap_valid_r;
  logic                  hit_gap, hit_x, hit_dna, hit_rna, hit_digit, hit_stop;
  logic                  step;

  // Decode the character
  always_comb begin
    hit_gap   = item.symbol inside {CH_DASH, CH_QUEST};
    hit_x     = (item.symbol == CH_X);
    hit_dna   = item.symbol inside {CH_A, CH_G, CH_C, CH_N, CH_T};
    hit_rna   = item.symbol inside {CH_A, CH_G, CH_C, CH_N, CH_U};
    hit_digit = item.symbol inside {[CH_0:CH_9]};
    hit_stop  = (item.symbol == CH_STAR);
  end

  // Counts including the current item
  always_comb begin
    step      = adv && item_valid;
    total_nxt = sat_inc(total_r, 1'b1);
    gap_nxt   = sat_inc(gap_r, hit_gap);
    x_nxt     = sat_inc(x_r, hit_x);
    dna_nxt   = sat_inc(dna_r, hit_dna);
    rna_nxt   = sat_inc(rna_r, hit_rna);
    digit_nxt = sat_inc(digit_r, hit_digit);
    stop_nxt  = sat_inc(stop_r, hit_stop);
  end

  // Advance the counters; clear them after the last item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r <= '0;
      gap_r   <= '0;
      x_r     <= '0;
      dna_r   <= '0;
      rna_r   <= '0;
      digit_r <= '0;
      stop_r  <= '0;
    end else if (step) begin
      if (item.last) begin
        total_r <= '0;
        gap_r   <= '0;
        x_r     <= '0;
        dna_r   <= '0;
        rna_r   <= '0;
        digit_r <= '0;
        stop_r  <= '0;
      end else begin
        total_r <= total_nxt;
        gap_r   <= gap_nxt;
        x_r     <= x_nxt;
        dna_r   <= dna_nxt;
        rna_r   <= rna_nxt;
        digit_r <= digit_nxt;
        stop_r  <= stop_nxt;
      end
    end
  end

  // Mark a snapshot when the last item passes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      snap_valid_r <= 1'b0;
    end else if (adv) begin
      snap_valid_r <= item_valid && item.last;
    end
  end

  // Capture the final counts
  always_ff @(posedge clk) begin
    if (step && item.last) begin
      snap_total_r <= total_nxt;
      snap_gap_r   <= gap_nxt;
      snap_x_r     <= x_nxt;
      snap_dna_r   <= dna_nxt;
      snap_rna_r   <= rna_nxt;
      snap_digit_r <= digit_nxt;
      snap_stop_r  <= stop_nxt;
    end
  end

  assign snap_valid = snap_valid_r;
  assign snap_total = snap_total_r;
  assign snap_gap   = snap_gap_r;
  assign snap_x     = snap_x_r;
  assign snap_dna   = snap_dna_r;
  assign snap_rna   = snap_rna_r;
  assign snap_digit = snap_digit_r;
  assign snap_stop  = snap_stop_r;

endmodule

@@ hdl/sac_classify.sv @@
// ---------------------------------------------------------------------------
// sac_classify
// Turns a snapshot of counts into a class code and nucleotide guess over
// three register stages, the last being the result register.
// ---------------------------------------------------------------------------
module sac_classify #(
  parameter int COUNT_BITS = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  adv,
  input  logic                  snap_valid,
  input  logic [COUNT_BITS-1:0] snap_total,
  input  logic [COUNT_BITS-1:0] snap_gap,
  input  logic [COUNT_BITS-1:0] snap_x,
  input  logic [COUNT_BITS-1:0] snap_dna,
  input  logic [COUNT_BITS-1:0] snap_rna,
  input  logic [COUNT_BITS-1:0] snap_digit,
  input  logic [COUNT_BITS-1:0] snap_stop,
  output logic                  res_valid,
  output sac_pkg::sac_out_t     res_item
);
  import sac_pkg::*;

  localparam int PROD_W = COUNT_BITS + PCT_BITS;

  // count*100 > den*95, exact
  function automatic logic over_95(
    input logic [COUNT_BITS-1:0] cnt,
    input logic [COUNT_BITS-1:0] den
  );
    over_95 = (PROD_W'(cnt) * PROD_W'(PCT_SCALE)) > (PROD_W'(den) * PROD_W'(PCT_LIMIT));
  endfunction

  // Stage 3: denominators and simple compares
  logic                  v3_r;
  logic [COUNT_BITS-1:0] nuc_den3_r, big3_r, dna3_r, rna3_r, digit3_r, x3_r;
  logic                  guess3_r, stop3_r, rna_le3_r;

  // Stage 4: fraction tests
  logic                  v4_r;
  logic [COUNT_BITS-1:0] dig_den4_r, digit4_r;
  logic                  dna95_4_r, rna95_4_r, half4_r, guess4_r, stop4_r, rna_le4_r;

  // Stage 5: result register
  logic                  res_valid_r;
  sac_out_t              res_item_r;
  logic                  dig95;
  logic [2:0]            code_nxt;

  // Hold all stages while the result waits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r        <= 1'b0;
      v4_r        <= 1'b0;
      res_valid_r <= 1'b0;
    end else if (adv) begin
      v3_r        <= snap_valid;
      v4_r        <= v3_r;
      res_valid_r <= v4_r;
    end
  end

  // Form the non-gap denominator and the nucleotide compares
  always_ff @(posedge clk) begin
    if (adv) begin
      nuc_den3_r <= (snap_total > snap_gap) ? snap_total - snap_gap : '0;
      big3_r     <= (snap_dna > snap_rna) ? snap_dna : snap_rna;
      guess3_r   <= (snap_dna > snap_rna) ? GUESS_DNA : GUESS_RNA;
      rna_le3_r  <= (snap_rna <= snap_dna);
      stop3_r    <= (snap_stop != '0);
      dna3_r     <= snap_dna;
      rna3_r     <= snap_rna;
      digit3_r   <= snap_digit;
      x3_r       <= snap_x;
    end
  end

  // Run the nucleotide fraction tests; form the digit denominator
  always_ff @(posedge clk) begin
    if (adv) begin
      dig_den4_r <= (nuc_den3_r > x3_r) ? nuc_den3_r - x3_r : '0;
      dna95_4_r  <= over_95(dna3_r, nuc_den3_r);
      rna95_4_r  <= over_95(rna3_r, nuc_den3_r);
      half4_r    <= {big3_r, 1'b0} > {1'b0, nuc_den3_r};
      digit4_r   <= digit3_r;
      guess4_r   <= guess3_r;
      stop4_r    <= stop3_r;
      rna_le4_r  <= rna_le3_r;
    end
  end

  // Pick the class in priority order
  always_comb begin
    dig95 = over_95(digit4_r, dig_den4_r);
    if (dna95_4_r && rna_le4_r) begin
      code_nxt = CODE_DNA;
    end else if (rna95_4_r) begin
      code_nxt = CODE_RNA;
    end else if (dig95) begin
      code_nxt = CODE_NUMERIC;
    end else if (half4_r) begin
      code_nxt = CODE_UNKNOWN;
    end else if (stop4_r) begin
      code_nxt = CODE_AA_STOP;
    end else begin
      code_nxt = CODE_AA;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      res_item_r.alphabet_code    <= code_nxt;
      res_item_r.nucleotide_guess <= guess4_r;
    end
  end

  assign res_valid = res_valid_r;
  assign res_item  = res_item_r;

endmodule

@@ hdl/sequence_alphabet_classifier.sv @@
// ---------------------------------------------------------------------------
// sequence_alphabet_classifier
// Streaming alphabet guess (DNA, RNA, numeric, amino acids) over a set of
// sequences fed one character per item.
// ---------------------------------------------------------------------------
// Takes one character per clock cycle while in_stall is low, and gives one
// result per item marked last once that item has passed the input register,
// counters and snapshot, denominator stage, fraction-test stage and result
// register. All stages move together: the pipeline holds, and in_stall rises,
// only in a cycle in which a result sits in the output register and out_stall
// is high. Counters saturate at 2^COUNT_BITS - 1 and are cleared after each
// last item, so a new set may start in the very next cycle.
`include "assert_macros.svh"

module sequence_alphabet_classifier #(
  parameter int COUNT_BITS = sac_pkg::DEF_COUNT_BITS
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  sac_pkg::sac_in_t  in_item,
  output logic              out_valid,
  input  logic              out_stall,
  output sac_pkg::sac_out_t out_item
);
  import sac_pkg::*;

  logic                  adv;
  logic                  s1_valid_r;
  sac_in_t               s1_item_r;
  logic                  snap_valid;
  logic [COUNT_BITS-1:0] snap_total, snap_gap, snap_x, snap_dna, snap_rna;
  logic [COUNT_BITS-1:0] snap_digit, snap_stop;

  // Advance unless a finished result is held
  assign adv      = !(out_valid && out_stall);
  assign in_stall = !adv;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (adv) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_item_r <= in_item;
    end
  end

  sac_counters #(
    .COUNT_BITS (COUNT_BITS)
  ) u_counters (
    .clk        (clk),
    .rst_n      (rst_n),
    .adv        (adv),
    .item_valid (s1_valid_r),
    .item       (s1_item_r),
    .snap_valid (snap_valid),
    .snap_total (snap_total),
    .snap_gap   (snap_gap),
    .snap_x     (snap_x),
    .snap_dna   (snap_dna),
    .snap_rna   (snap_rna),
    .snap_digit (snap_digit),
    .snap_stop  (snap_stop)
  );

  sac_classify #(
    .COUNT_BITS (COUNT_BITS)
  ) u_classify (
    .clk        (clk),
    .rst_n      (rst_n),
    .adv        (adv),
    .snap_valid (snap_valid),
    .snap_total (snap_total),
    .snap_gap   (snap_gap),
    .snap_x     (snap_x),
    .snap_dna   (snap_dna),
    .snap_rna   (snap_rna),
    .snap_digit (snap_digit),
    .snap_stop  (snap_stop),
    .res_valid  (out_valid),
    .res_item   (out_item)
  );

  // A snapshot follows exactly the last items that advance
  `AST_NEXT(a_snap_on_last, clk, rst_n, adv,
            snap_valid == $past(s1_valid_r && s1_item_r.last),
            "snapshot does not match last item")
  // A held pipeline keeps its snapshot marker
  `AST_NEXT(a_snap_hold, clk, rst_n, !adv, $stable(snap_valid), "snapshot moved while held")
  // Nothing is valid right after reset
  `AST_ALWAYS(a_reset_clear, clk, rst_n && !$past(rst_n),
              !out_valid && !snap_valid && !s1_valid_r, "valid after reset")

endmodule
